// ===== hw/rtl/favs_pkg.sv =====
`timescale 1ns / 1ps
package favs_pkg;

  // Event kinds carried in the func field.
  localparam logic [1:0] FUNC_REF   = 2'd0;
  localparam logic [1:0] FUNC_ALLOC = 2'd1;
  localparam logic [1:0] FUNC_FREE  = 2'd2;

  localparam int FRAME_W = 6;
  localparam int AGE_W   = 8;
  localparam logic [AGE_W-1:0] AGE_TOP = 8'd128;

  // Operations a cell applies to its own entry in one rotation step.
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_ROT,
    OP_CLOCK,
    OP_AGE
  } cell_op_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CLOCK,
    ST_AGE,
    ST_MIN,
    ST_GRANT,
    ST_OUT
  } state_e;

  // One frame's entry as it travels along the ring.
  typedef struct packed {
    logic             in_use;
    logic             is_page;
    logic             accessed;
    logic [AGE_W-1:0] age;
  } entry_t;

endpackage

// ===== hw/rtl/frame_allocator_victim_select.sv =====
`timescale 1ns / 1ps
// After the input beat, reference and free rotate the ring to bring the frame into cell 0 and
// update it. Allocate first scans one lap for an unused frame and, on a full table, runs the
// clock pass or the aging pass before it grants.
// Flow: one item at a time; the next beat can be taken in the cycle after the result beat.
// Reset: asynchronous active low; all frames unused, page type, not accessed, age zero,
// clock hand zero, policy second chance.
module frame_allocator_victim_select
  import favs_pkg::*;
#(
  parameter int NUM_FRAMES = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // frame[5:0], holds_page[6]
  input  logic [1:0] s_axis_tuser,   // func[1:0]
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // granted_frame[5:0], evicted[6], error[7]
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i
);

  localparam int IDX_W = $clog2(NUM_FRAMES);
  localparam int CNT_W = $clog2(2 * NUM_FRAMES + 1);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(NUM_FRAMES - 1);

  state_e state_q, state_d;
  logic policy_q;
  logic [1:0] func_q;
  logic [FRAME_W-1:0] frame_q;
  logic holds_q;
  // Position of the frame held in cell 0 (ring rotates toward lower cells' index).
  logic [IDX_W-1:0] pos_q, pos_d;
  logic [IDX_W-1:0] hand_q, hand_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic found_q, found_d;
  logic [IDX_W-1:0] vic_q, vic_d;
  logic [AGE_W-1:0] best_q, best_d;
  logic [7:0] out_q, out_d;
  logic out_v_q;

  cell_op_e op;
  cell_op_e op_rest;
  entry_t   ent [NUM_FRAMES];
  logic     wr;
  entry_t   wr_data;
  entry_t   head;
  logic     in_range;

  // Cell 0 takes its entry from cell 1, the last from cell 0: a ring.
  // Only the last cell, which receives the head entry, applies a clock or aging update.
  for (genvar g = 0; g < NUM_FRAMES; g++) begin : g_cell
    favs_cell u_cell (
      .clk_i,
      .rst_ni,
      .op_i      ((g == NUM_FRAMES - 1) ? op : op_rest),
      .prev_i    (ent[(g + 1) % NUM_FRAMES]),
      .wr_i      (wr && (g == 0)),
      .wr_data_i (wr_data),
      .entry_o   (ent[g])
    );
  end

  assign op_rest  = (op == OP_CLOCK || op == OP_AGE) ? OP_ROT : op;
  assign head     = ent[0];
  assign in_range = {{(16 - FRAME_W){1'b0}}, frame_q} < 16'(NUM_FRAMES);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= 1'b0;
    end else if (cfg_we_i) begin
      policy_q <= cfg_wdata_i;
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;

  // Next state and bookkeeping.
  always_comb begin
    state_d = state_q;
    pos_d   = pos_q;
    hand_d  = hand_q;
    cnt_d   = cnt_q;
    found_d = found_q;
    vic_d   = vic_q;
    best_d  = best_q;
    out_d   = out_q;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          cnt_d   = '0;
          found_d = 1'b0;
          out_d   = '0;
          state_d = (s_axis_tuser == FUNC_ALLOC) ? ST_SCAN : ST_GRANT;
        end
      end
      ST_SCAN: begin
        // One lap of the ring while noting the lowest unused frame.
        if (cnt_q != '0 && !head.in_use && (!found_q || pos_q < vic_q)) begin
          found_d = 1'b1;
          vic_d   = pos_q;
        end
        if (cnt_q == CNT_W'(NUM_FRAMES)) begin
          if (found_d) begin
            state_d = ST_GRANT;
          end else begin
            cnt_d   = '0;
            state_d = policy_q ? ST_AGE : ST_CLOCK;
          end
        end else begin
          if (cnt_q != '0) pos_d = (pos_q == LAST) ? '0 : pos_q + 1'b1;
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_CLOCK: begin
        // Cell 0 inspects frames starting at the hand, two laps at most.
        if (cnt_q < CNT_W'(NUM_FRAMES) && pos_q != hand_q && cnt_q == '0) begin
          pos_d = (pos_q == LAST) ? '0 : pos_q + 1'b1;
        end else if (head.is_page && !head.accessed) begin
          vic_d   = pos_q;
          found_d = 1'b1;
          hand_d  = (pos_q == LAST) ? '0 : pos_q + 1'b1;
          state_d = ST_GRANT;
        end else if (cnt_q == CNT_W'(2 * NUM_FRAMES - 1)) begin
          state_d = ST_GRANT;
        end else begin
          cnt_d = cnt_q + 1'b1;
          pos_d = (pos_q == LAST) ? '0 : pos_q + 1'b1;
        end
      end
      ST_AGE: begin
        // One full lap ages every page frame.
        pos_d = (pos_q == LAST) ? '0 : pos_q + 1'b1;
        if (cnt_q == CNT_W'(NUM_FRAMES - 1)) begin
          cnt_d   = '0;
          best_d  = '1;
          state_d = ST_MIN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_MIN: begin
        // Another lap finds the smallest age, the lower index winning a tie.
        if (head.is_page && (!found_q || head.age < best_q ||
                             (head.age == best_q && pos_q < vic_q))) begin
          found_d = 1'b1;
          best_d  = head.age;
          vic_d   = pos_q;
        end
        pos_d = (pos_q == LAST) ? '0 : pos_q + 1'b1;
        if (cnt_q == CNT_W'(NUM_FRAMES - 1)) begin
          state_d = ST_GRANT;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_GRANT: begin
        // Rotate until the target frame sits in cell 0, then update it.
        if (func_q == FUNC_ALLOC && found_q && pos_q != vic_q) begin
          pos_d = (pos_q == LAST) ? '0 : pos_q + 1'b1;
        end else if (func_q != FUNC_ALLOC && in_range &&
                     pos_q != IDX_W'(frame_q)) begin
          pos_d = (pos_q == LAST) ? '0 : pos_q + 1'b1;
        end else begin
          if (func_q == FUNC_ALLOC) begin
            if (found_q) out_d = {1'b0, head.in_use, FRAME_W'(vic_q)};
            else         out_d = {1'b1, 1'b0, {FRAME_W{1'b0}}};
          end
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (m_axis_tready) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Ring control and the write into cell 0.
  always_comb begin
    op      = OP_HOLD;
    wr      = 1'b0;
    wr_data = head;
    case (state_q)
      ST_SCAN: if (cnt_q != '0 && cnt_q != CNT_W'(NUM_FRAMES)) op = OP_ROT;
      ST_CLOCK: begin
        if (cnt_q < CNT_W'(NUM_FRAMES) && pos_q != hand_q && cnt_q == '0) begin
          op = OP_ROT;
        end else if (!(head.is_page && !head.accessed) &&
                     cnt_q != CNT_W'(2 * NUM_FRAMES - 1)) begin
          op = OP_CLOCK;
        end
      end
      ST_AGE:  op = OP_AGE;
      ST_MIN:  op = OP_ROT;
      ST_GRANT: begin
        if (func_q == FUNC_ALLOC && found_q && pos_q != vic_q) begin
          op = OP_ROT;
        end else if (func_q != FUNC_ALLOC && in_range &&
                     pos_q != IDX_W'(frame_q)) begin
          op = OP_ROT;
        end else begin
          case (func_q)
            FUNC_REF: begin
              wr = in_range;
              wr_data.accessed = 1'b1;
            end
            FUNC_FREE: begin
              wr = in_range;
              wr_data = '{in_use: 1'b0, is_page: 1'b1, accessed: 1'b0, age: '0};
            end
            FUNC_ALLOC: begin
              wr = found_q;
              wr_data = '{in_use: 1'b1, is_page: holds_q, accessed: 1'b0, age: '0};
            end
            default: wr = 1'b0;
          endcase
        end
      end
      default: op = OP_HOLD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pos_q   <= '0;
      hand_q  <= '0;
      cnt_q   <= '0;
      found_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      hand_q  <= hand_d;
      cnt_q   <= cnt_d;
      found_q <= found_d;
      out_v_q <= (state_d == ST_OUT);
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    vic_q  <= vic_d;
    best_q <= best_d;
    out_q  <= out_d;
    if (state_q == ST_IDLE && s_axis_tvalid) begin
      func_q  <= s_axis_tuser;
      frame_q <= s_axis_tdata[5:0];
      holds_q <= s_axis_tdata[6];
    end
  end

endmodule

// ===== hw/rtl/favs_cell.sv =====
`timescale 1ns / 1ps
module favs_cell
  import favs_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cell_op_e op_i,
  input  entry_t   prev_i,
  input  logic     wr_i,
  input  entry_t   wr_data_i,
  output entry_t   entry_o
);

  entry_t entry_q, entry_d;
  logic [AGE_W:0] sum;

  // Aging of the entry coming in from the neighbor.
  always_comb begin
    sum = {1'b0, 1'b0, prev_i.age[AGE_W-1:1]} + {1'b0, AGE_TOP};
  end

  always_comb begin
    entry_d = entry_q;
    case (op_i)
      OP_HOLD: entry_d = entry_q;
      OP_ROT:  entry_d = prev_i;
      OP_CLOCK: begin
        entry_d = prev_i;
        if (prev_i.is_page) entry_d.accessed = 1'b0;
      end
      OP_AGE: begin
        entry_d = prev_i;
        if (prev_i.is_page) begin
          entry_d.accessed = 1'b0;
          if (prev_i.accessed) begin
            entry_d.age = sum[AGE_W] ? {AGE_W{1'b1}} : sum[AGE_W-1:0];
          end else begin
            entry_d.age = {1'b0, prev_i.age[AGE_W-1:1]};
          end
        end
      end
      default: entry_d = entry_q;
    endcase
    if (wr_i) entry_d = wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '{in_use: 1'b0, is_page: 1'b1, accessed: 1'b0, age: '0};
    end else begin
      entry_q <= entry_d;
    end
  end

  assign entry_o = entry_q;

endmodule

// ===== tb/tb_frame_allocator_victim_select.sv =====
`timescale 1ns / 1ps
module tb_frame_allocator_victim_select;
  import favs_pkg::*;

  localparam int NFR = 64;
  localparam logic [1:0] FUNC_NONE = 2'd3;

  typedef struct packed {
    logic [1:0] func;
    logic [5:0] frame;
    logic       holds_page;
  } event_t;

  typedef struct packed {
    logic [5:0] granted;
    logic       evicted;
    logic       error;
  } grant_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [7:0] s_axis_tdata = '0;
  logic [1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic cfg_we_i = 1'b0;
  logic cfg_wdata_i = 1'b0;

  // Predictor state for the frame table.
  logic             tbl_in_use [NFR];
  logic             tbl_is_page [NFR];
  logic             tbl_accessed [NFR];
  logic [AGE_W-1:0] tbl_age [NFR];
  logic [5:0]       hand;
  logic             policy_q;

  event_t pending_events[$];
  grant_t expected_grants[$];
  int     n_errors = 0;
  int     hold_off = 0;
  int     long_stall = 0;
  bit     quiet = 1'b0;
  int     src_gap = 0;
  int     dst_gap = 0;
  logic   in_acc_q = 1'b0;

  always #5 clk_i = ~clk_i;

  frame_allocator_victim_select #(.NUM_FRAMES(NFR)) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    n_errors++;
  endtask

  function automatic void give_frame(input int f, input logic holds);
    tbl_in_use[f]   = 1'b1;
    tbl_is_page[f]  = holds;
    tbl_accessed[f] = 1'b0;
    tbl_age[f]      = '0;
  endfunction

  // Compute the grant for one event and advance the table.
  function automatic grant_t predict_grant(input event_t ev);
    grant_t r;
    int     pos;
    int     a;
    int     best;
    bit     found;
    r = '0;
    found = 1'b0;
    if (ev.func == FUNC_REF) begin
      tbl_accessed[ev.frame] = 1'b1;
    end else if (ev.func == FUNC_FREE) begin
      tbl_in_use[ev.frame]   = 1'b0;
      tbl_is_page[ev.frame]  = 1'b1;
      tbl_accessed[ev.frame] = 1'b0;
      tbl_age[ev.frame]      = '0;
    end else if (ev.func == FUNC_ALLOC) begin
      for (int f = 0; f < NFR; f++) begin
        if (!tbl_in_use[f]) begin
          give_frame(f, ev.holds_page);
          r.granted = 6'(f);
          return r;
        end
      end
      if (!policy_q) begin
        pos = hand;
        for (int n = 0; n < 2 * NFR && !found; n++) begin
          if (tbl_is_page[pos] && tbl_accessed[pos]) begin
            tbl_accessed[pos] = 1'b0;
          end else if (tbl_is_page[pos]) begin
            found = 1'b1;
            r.granted = 6'(pos);
            hand = 6'((pos + 1) % NFR);
          end
          if (!found) pos = (pos + 1) % NFR;
        end
      end else begin
        best = 256;
        for (int f = 0; f < NFR; f++) begin
          if (tbl_is_page[f]) begin
            a = tbl_age[f] >> 1;
            if (tbl_accessed[f]) begin
              tbl_accessed[f] = 1'b0;
              a = (a + 128 > 255) ? 255 : a + 128;
            end
            tbl_age[f] = AGE_W'(a);
          end
        end
        for (int f = 0; f < NFR; f++) begin
          if (tbl_is_page[f] && tbl_age[f] < best) begin
            best = tbl_age[f];
            r.granted = 6'(f);
            found = 1'b1;
          end
        end
      end
      if (found) begin
        give_frame(r.granted, ev.holds_page);
        r.evicted = 1'b1;
      end else begin
        r.error = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic event_t mk_event(input logic [1:0] fn, input int fr, input logic hp);
    event_t ev;
    ev.func = fn;
    ev.frame = 6'(fr);
    ev.holds_page = hp;
    return ev;
  endfunction

  // Mostly allocations and references with some frees, so the table stays full.
  function automatic event_t random_event();
    int k;
    k = $urandom_range(0, 99);
    if (k < 40) return mk_event(FUNC_ALLOC, $urandom_range(0, 63), ($urandom_range(0, 7) != 0));
    if (k < 80) return mk_event(FUNC_REF, $urandom_range(0, 63), 1'($urandom_range(0, 1)));
    if (k < 97) return mk_event(FUNC_FREE, $urandom_range(0, 63), 1'($urandom_range(0, 1)));
    return mk_event(FUNC_NONE, $urandom_range(0, 63), 1'($urandom_range(0, 1)));
  endfunction

  // Acceptance seen at the rising edge; the prediction happens here.
  always @(posedge clk_i) begin
    in_acc_q <= rst_ni && s_axis_tvalid && s_axis_tready;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      expected_grants.push_back(predict_grant(pending_events.pop_front()));
    end
  end

  // Driver: present the oldest pending beat, with random idle bursts.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && !in_acc_q) begin
        // The offered beat waits unchanged until it is taken.
      end else if (src_gap > 0) begin
        src_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_events.size() != 0) begin
        if (!quiet && $urandom_range(0, 15) == 0) begin
          src_gap = $urandom_range(0, 10);
          s_axis_tvalid <= 1'b0;
        end else begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {1'b0, pending_events[0].holds_page, pending_events[0].frame};
          s_axis_tuser  <= pending_events[0].func;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver stall control.
  always @(negedge clk_i) begin
    if (long_stall > 0) begin
      long_stall--;
      m_axis_tready <= 1'b0;
    end else if (dst_gap > 0) begin
      dst_gap--;
      m_axis_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 15) == 0) begin
      dst_gap = $urandom_range(0, 10);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Monitor: compare each result beat with the oldest expectation.
  always @(posedge clk_i) begin
    grant_t got;
    grant_t exp_g;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[5:0], m_axis_tdata[6], m_axis_tdata[7]};
      if (expected_grants.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        exp_g = expected_grants.pop_front();
        if (got.granted !== exp_g.granted)
          report_mismatch($sformatf("granted_frame %0d, expected %0d", got.granted, exp_g.granted));
        if (got.evicted !== exp_g.evicted)
          report_mismatch($sformatf("evicted %b, expected %b", got.evicted, exp_g.evicted));
        if (got.error !== exp_g.error)
          report_mismatch($sformatf("error %b, expected %b", got.error, exp_g.error));
      end
    end
  end

  task automatic wait_drained();
    while (pending_events.size() != 0 || expected_grants.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_policy(input logic pol);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= pol;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    policy_q = pol;
  endtask

  // Stimulus phases.
  initial begin
    for (int f = 0; f < NFR; f++) begin
      tbl_in_use[f] = 1'b0;
      tbl_is_page[f] = 1'b1;
      tbl_accessed[f] = 1'b0;
      tbl_age[f] = '0;
    end
    hand = '0;
    policy_q = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: fill with tables and pages, then exercise every event kind.
    pending_events.push_back(mk_event(FUNC_REF, 63, 1'b1));
    pending_events.push_back(mk_event(FUNC_NONE, 63, 1'b1));
    for (int i = 0; i < NFR; i++) pending_events.push_back(mk_event(FUNC_ALLOC, 0, i >= 2));
    pending_events.push_back(mk_event(FUNC_REF, 2, 1'b0));
    pending_events.push_back(mk_event(FUNC_ALLOC, 0, 1'b1));
    pending_events.push_back(mk_event(FUNC_FREE, 63, 1'b0));
    pending_events.push_back(mk_event(FUNC_FREE, 63, 1'b0));
    pending_events.push_back(mk_event(FUNC_ALLOC, 0, 1'b0));
    wait_drained();

    // Every frame a table: allocation has no victim.
    for (int i = 0; i < NFR; i++) pending_events.push_back(mk_event(FUNC_FREE, i, 1'b0));
    for (int i = 0; i < NFR; i++) pending_events.push_back(mk_event(FUNC_ALLOC, 0, 1'b0));
    pending_events.push_back(mk_event(FUNC_ALLOC, 0, 1'b1));
    for (int i = 0; i < NFR; i++) pending_events.push_back(mk_event(FUNC_FREE, i, 1'b1));
    wait_drained();

    // Random phases alternating policies, with a long receiver stall.
    for (int ph = 0; ph < 6; ph++) begin
      write_policy(ph[0]);
      if (ph == 5) quiet = 1'b1;
      if (ph == 2) long_stall = 300;
      for (int i = 0; i < 260; i++) pending_events.push_back(random_event());
      wait_drained();
    end
    repeat (3 * NFR) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("status: fail");
    $finish;
  end

endmodule

// ===== frame_allocator_victim_select.f =====
hw/rtl/favs_pkg.sv
hw/rtl/favs_cell.sv
hw/rtl/frame_allocator_victim_select.sv
tb/tb_frame_allocator_victim_select.sv
